// File: hdl/srs_pkg.sv
package srs_pkg;

	localparam int MAX_PATTERN     = 8;
	localparam int MAX_REPLACEMENT = 8;
	localparam int CFG_DATA_W      = 64;
	localparam int CFG_INDEX_W     = 2;
	localparam int LEN_W           = 4;
	localparam int MAX_RESULTS     = 8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_BYTES      = 2'd0,
		REG_PATTERN_LENGTH     = 2'd1,
		REG_REPLACEMENT_BYTES  = 2'd2,
		REG_REPLACEMENT_LENGTH = 2'd3
	} cfg_reg_t;

	// One accepted text byte turns into this group of result beats.
	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] bytes;
		logic [LEN_W-1:0]            count;
		logic                        last;
		logic                        present;
	} emit_t;

endpackage

// File: hdl/srs_emit.sv
module srs_emit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  srs_pkg::emit_t load_data,
	output logic          can_load,
	output logic          result_valid,
	input  logic          result_ready,
	output logic [7:0]    out_byte,
	output logic          byte_present,
	output logic          out_last
);
	import srs_pkg::*;

	logic [MAX_RESULTS-1:0][7:0] bytes_s1;
	logic [LEN_W-1:0]            rem_q;
	logic                        last_s1;
	logic                        present_s1;
	logic                        beat;

	assign beat         = result_valid && result_ready;
	assign result_valid = (rem_q != '0);
	assign can_load     = (rem_q == '0) || ((rem_q == LEN_W'(1)) && result_ready);
	assign out_byte     = bytes_s1[0];
	assign byte_present = present_s1;
	assign out_last     = last_s1 && (rem_q == LEN_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= load_data.count;
		end else if (beat) begin
			rem_q <= rem_q - LEN_W'(1);
		end
	end

	// The byte vector shifts down one place per beat so the head is always at index 0.
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_s1   <= load_data.bytes;
			last_s1    <= load_data.last;
			present_s1 <= load_data.present;
		end else if (beat) begin
			for (int i = 0; i < MAX_RESULTS - 1; i++) begin
				bytes_s1[i] <= bytes_s1[i+1];
			end
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> ((rem_q == '0) || ((rem_q == LEN_W'(1)) && result_ready)))
		else $error("group loaded over pending beats");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> ($stable(rem_q) && $stable(bytes_s1[0])))
		else $error("stalled beat changed");

	a_marker_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !byte_present) |-> (out_last && (rem_q == LEN_W'(1))))
		else $error("end marker not a lone final beat");

endmodule

// File: hdl/substring_replace_stream.sv
// The first result beat of a text byte is offered in the cycle after that byte is accepted.
// Throughput: one text byte per cycle while each byte yields at most one beat and result_ready is
// high; a byte that yields several beats (replacement or final flush) holds the input until its last
// beat is taken, since the single output register sends one beat per cycle.
// Reset clears the window count and the pending beat count of the output register and sets the
// configuration registers to their defaults; the window bytes and held output bytes are not reset.
module substring_replace_stream (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [srs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [srs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            text_valid,
	output logic                            text_ready,
	input  logic [7:0]                      text_byte,
	input  logic                            text_last,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [7:0]                      out_byte,
	output logic                            byte_present,
	output logic                            out_last
);
	import srs_pkg::*;

	logic [MAX_PATTERN-1:0][7:0]     pat_q;
	logic [MAX_REPLACEMENT-1:0][7:0] repl_q;
	logic [LEN_W-1:0]                plen_raw_q;
	logic [LEN_W-1:0]                rlen_raw_q;
	logic [MAX_PATTERN-1:0][7:0]     win_q;
	logic [LEN_W-1:0]                cnt_q;

	logic [LEN_W-1:0]            plen;
	logic [LEN_W-1:0]            rlen;
	logic [LEN_W-1:0]            wc;
	logic [LEN_W-1:0]            nc;
	logic [MAX_PATTERN-1:0][7:0] w;
	logic [MAX_PATTERN-1:0][7:0] w_shift;
	logic                        full;
	logic                        match;
	logic                        accept;
	logic                        can_load;
	emit_t                       grp;
	logic [LEN_W-1:0]            cnt_next;

	assign accept     = text_valid && text_ready;
	assign text_ready = can_load;

	always_comb begin
		if (plen_raw_q == '0) begin
			plen = LEN_W'(1);
		end else if (plen_raw_q > LEN_W'(MAX_PATTERN)) begin
			plen = LEN_W'(MAX_PATTERN);
		end else begin
			plen = plen_raw_q;
		end
		rlen = (rlen_raw_q > LEN_W'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT) : rlen_raw_q;
	end

	always_comb begin
		wc = (cnt_q >= plen) ? '0 : cnt_q;
		nc = wc + LEN_W'(1);
		full = (nc == plen);
		for (int i = 0; i < MAX_PATTERN; i++) begin
			w[i] = (wc == LEN_W'(i)) ? text_byte : win_q[i];
		end
		for (int i = 0; i < MAX_PATTERN - 1; i++) begin
			w_shift[i] = w[i+1];
		end
		w_shift[MAX_PATTERN-1] = w[MAX_PATTERN-1];
		match = full;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if ((LEN_W'(i) < plen) && (w[i] != pat_q[i])) begin
				match = 1'b0;
			end
		end
	end

	// A released byte on the final beat is followed by the whole remaining window, so the
	// group is simply the updated window in order.
	always_comb begin
		grp.last    = text_last;
		grp.present = 1'b1;
		grp.bytes   = w;
		grp.count   = '0;
		cnt_next    = nc;
		if (match) begin
			grp.bytes = repl_q;
			grp.count = rlen;
			cnt_next  = '0;
		end else if (text_last) begin
			grp.count = nc;
			cnt_next  = '0;
		end else if (full) begin
			grp.count = LEN_W'(1);
			cnt_next  = wc;
		end
		if (text_last && (grp.count == '0)) begin
			grp.bytes   = '0;
			grp.count   = LEN_W'(1);
			grp.present = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q      <= '0;
			repl_q     <= '0;
			plen_raw_q <= LEN_W'(1);
			rlen_raw_q <= '0;
			cnt_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_PATTERN_BYTES: begin
						pat_q <= cfg_data;
					end
					REG_PATTERN_LENGTH: begin
						plen_raw_q <= cfg_data[LEN_W-1:0];
						cnt_q      <= '0;
					end
					REG_REPLACEMENT_BYTES: begin
						repl_q <= cfg_data;
					end
					REG_REPLACEMENT_LENGTH: begin
						rlen_raw_q <= cfg_data[LEN_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (accept) begin
				cnt_q <= cnt_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !match && !text_last) begin
			win_q <= full ? w_shift : w;
		end
	end

	srs_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept && (grp.count != '0)),
		.load_data    (grp),
		.can_load     (can_load),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_byte     (out_byte),
		.byte_present (byte_present),
		.out_last     (out_last)
	);

	a_count_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg_we) |=> (cnt_q < plen))
		else $error("window count reached pattern length");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && text_last) |=> (cnt_q == '0))
		else $error("window not cleared after final byte");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && text_last) |=> result_valid)
		else $error("final byte produced no result");

endmodule

// File: dv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import srs_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} text_item_t;

	typedef struct {
		logic [7:0] data;
		logic       present;
		logic       last;
	} beat_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	cfg_reg_t              cfg_index = REG_PATTERN_BYTES;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  text_valid = 1'b0;
	logic                  text_ready;
	logic [7:0]            text_byte = 8'h00;
	logic                  text_last = 1'b0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	logic [7:0]            out_byte;
	logic                  byte_present;
	logic                  out_last;

	// Shadow copy of the block's registers and search window.
	logic [63:0]    pat_bytes = '0;
	logic [LEN_W-1:0] pat_len = 4'd1;
	logic [63:0]    rep_bytes = '0;
	logic [LEN_W-1:0] rep_len = 4'd0;
	logic [7:0]     win [MAX_PATTERN];
	int             win_cnt = 0;

	text_item_t text_q [$];
	beat_t      rewritten_q [$];
	logic [7:0] alph [4];

	int  send_idle = 33;
	int  recv_idle = 70;
	int  stall_left = 0;
	int  items_sent = 0;
	int  errors = 0;
	int  cycles = 0;
	bit  text_taken = 1'b0;

	substring_replace_stream uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.text_valid   (text_valid),
		.text_ready   (text_ready),
		.text_byte    (text_byte),
		.text_last    (text_last),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_byte     (out_byte),
		.byte_present (byte_present),
		.out_last     (out_last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int eff_pattern_len();
		if (pat_len == 4'd0)
			return 1;
		if (int'(pat_len) > MAX_PATTERN)
			return MAX_PATTERN;
		return int'(pat_len);
	endfunction

	// Advances the shadow window by one text byte and queues the beats it produces.
	function automatic void apply_text_byte(input logic [7:0] b, input logic last);
		beat_t produced [16];
		int    n;
		int    plen;
		int    rlen;
		int    i;
		bit    hit;
		n = 0;
		plen = eff_pattern_len();
		rlen = (int'(rep_len) > MAX_REPLACEMENT) ? MAX_REPLACEMENT : int'(rep_len);
		if (win_cnt >= plen)
			win_cnt = 0;
		win[win_cnt] = b;
		win_cnt++;
		if (win_cnt == plen) begin
			hit = 1'b1;
			for (i = 0; i < plen; i++)
				if (win[i] != pat_bytes[8*i +: 8])
					hit = 1'b0;
			if (hit) begin
				for (i = 0; i < rlen; i++) begin
					produced[n] = '{rep_bytes[8*i +: 8], 1'b1, 1'b0};
					n++;
				end
				win_cnt = 0;
			end else begin
				produced[n] = '{win[0], 1'b1, 1'b0};
				n++;
				for (i = 0; i < win_cnt - 1; i++)
					win[i] = win[i+1];
				win_cnt--;
			end
		end
		if (last) begin
			for (i = 0; i < win_cnt; i++) begin
				produced[n] = '{win[i], 1'b1, 1'b0};
				n++;
			end
			win_cnt = 0;
			if (n == 0) begin
				produced[0] = '{8'h00, 1'b0, 1'b1};
				n = 1;
			end else begin
				produced[n-1].last = 1'b1;
			end
		end
		for (i = 0; i < n; i++)
			rewritten_q.push_back(produced[i]);
	endfunction

	// Register writes and accepted text bytes update the shadow state at the edge they land.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PATTERN_BYTES: begin
						pat_bytes = cfg_data;
					end
					REG_PATTERN_LENGTH: begin
						pat_len = cfg_data[LEN_W-1:0];
						win_cnt = 0;
					end
					REG_REPLACEMENT_BYTES: begin
						rep_bytes = cfg_data;
					end
					REG_REPLACEMENT_LENGTH: begin
						rep_len = cfg_data[LEN_W-1:0];
					end
					default: begin
					end
				endcase
			end
			text_taken = text_valid && text_ready;
			if (text_taken)
				apply_text_byte(text_byte, text_last);
		end else begin
			text_taken = 1'b0;
		end
	end

	always @(negedge clk) begin
		text_item_t nxt;
		if (!(text_valid && !text_taken)) begin
			if (text_q.size() != 0 && $urandom_range(99) >= send_idle) begin
				nxt = text_q.pop_front();
				text_valid <= 1'b1;
				text_byte <= nxt.data;
				text_last <= nxt.last;
			end else begin
				text_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		beat_t want;
		if (arst_n && result_valid && result_ready) begin
			if (rewritten_q.size() == 0) begin
				if (errors < 40)
					$display("%0t: beat with nothing pending: byte=%h present=%b last=%b",
						$time, out_byte, byte_present, out_last);
				errors++;
			end else begin
				want = rewritten_q.pop_front();
				if (want.data !== out_byte || want.present !== byte_present ||
						want.last !== out_last) begin
					if (errors < 40)
						$display("%0t: mismatch: expected %h/%b/%b, actual %h/%b/%b",
							$time, want.data, want.present, want.last,
							out_byte, byte_present, out_last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send(input logic [7:0] b, input logic last);
		text_q.push_back('{b, last});
		items_sent++;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every queued byte is taken and every predicted beat has come out.
	task automatic settle();
		while (text_q.size() != 0 || text_valid || rewritten_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic pick_setting();
		logic [63:0]      pb;
		logic [63:0]      word;
		logic [LEN_W-1:0] pl;
		logic [LEN_W-1:0] rl;
		int               r;
		int               i;
		for (i = 0; i < 4; i++)
			alph[i] = 8'($urandom_range(255));
		// Patterns drawn from a tiny alphabet make partial and overlapping hits common.
		for (i = 0; i < 8; i++)
			pb[8*i +: 8] = ($urandom_range(99) < 80) ? alph[$urandom_range(3)]
				: 8'($urandom_range(255));
		r = $urandom_range(99);
		if (r < 10)
			pl = 4'd8;
		else if (r < 15)
			pl = 4'd0;
		else if (r < 20)
			pl = 4'($urandom_range(15, 9));
		else if (r < 45)
			pl = 4'd1;
		else
			pl = 4'($urandom_range(7, 2));
		rl = ($urandom_range(99) < 10) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
		write_reg(REG_PATTERN_BYTES, pb);
		word = {$urandom, $urandom};
		word[LEN_W-1:0] = pl;
		write_reg(REG_PATTERN_LENGTH, word);
		write_reg(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
		word = {$urandom, $urandom};
		word[LEN_W-1:0] = rl;
		write_reg(REG_REPLACEMENT_LENGTH, word);
	endtask

	// A text built from whole patterns, broken prefixes, alphabet bytes and noise.
	task automatic queue_text();
		logic [7:0] bytes_q [$];
		int         chunks;
		int         plen;
		int         r;
		int         m;
		int         k;
		plen = eff_pattern_len();
		chunks = $urandom_range(5, 1);
		repeat (chunks) begin
			r = $urandom_range(99);
			if (r < 40) begin
				for (k = 0; k < plen; k++)
					bytes_q.push_back(pat_bytes[8*k +: 8]);
			end else if (r < 55) begin
				m = $urandom_range(plen, 1);
				for (k = 0; k < m; k++)
					bytes_q.push_back(pat_bytes[8*k +: 8]);
			end else if (r < 80) begin
				bytes_q.push_back(alph[$urandom_range(3)]);
			end else begin
				bytes_q.push_back(8'($urandom_range(255)));
			end
		end
		for (k = 0; k < bytes_q.size(); k++)
			send(bytes_q[k], k == bytes_q.size() - 1);
	endtask

	task automatic run_random(input int n_items);
		int start;
		start = items_sent;
		pick_setting();
		while (items_sent - start < n_items) begin
			if ($urandom_range(99) < 35) begin
				settle();
				pick_setting();
			end
			queue_text();
		end
		settle();
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Default setting deletes every zero byte; a lone zero leaves only the end marker.
		send(8'h00, 1'b0);
		send(8'hFF, 1'b0);
		send(8'h00, 1'b1);
		send(8'h00, 1'b1);
		settle();

		write_reg(REG_PATTERN_BYTES, 64'h6261);
		write_reg(REG_PATTERN_LENGTH, 64'd2);
		write_reg(REG_REPLACEMENT_BYTES, 64'h5A5958);
		write_reg(REG_REPLACEMENT_LENGTH, 64'd3);
		send(8'h78, 1'b0);
		send(8'h61, 1'b0);
		send(8'h61, 1'b0);
		send(8'h62, 1'b0);
		send(8'h61, 1'b0);
		send(8'h62, 1'b0);
		send(8'h61, 1'b1);
		settle();

		// Rewriting the pattern length mid-text drops the byte held in the window.
		send(8'h61, 1'b0);
		settle();
		write_reg(REG_PATTERN_LENGTH, 64'd2);
		send(8'h62, 1'b1);
		settle();

		write_reg(REG_PATTERN_BYTES, '1);
		write_reg(REG_PATTERN_LENGTH, 64'd8);
		write_reg(REG_REPLACEMENT_BYTES, '0);
		write_reg(REG_REPLACEMENT_LENGTH, 64'd8);
		repeat (8) send(8'hFF, 1'b0);
		send(8'hFF, 1'b1);
		settle();

		// Out-of-range lengths saturate; a zero pattern length acts as one.
		write_reg(REG_PATTERN_LENGTH, 64'd0);
		write_reg(REG_REPLACEMENT_LENGTH, 64'd12);
		send(8'hFF, 1'b1);
		settle();
		write_reg(REG_PATTERN_LENGTH, 64'd15);
		write_reg(REG_REPLACEMENT_LENGTH, 64'd0);
		send(8'hFF, 1'b0);
		send(8'h00, 1'b0);
		send(8'hFF, 1'b1);
		settle();

		run_random(95);

		send_idle = 70;
		recv_idle = 33;
		run_random(95);

		send_idle = 0;
		recv_idle = 0;
		stall_left = 300;
		run_random(95);

		repeat (8) @(posedge clk);
		if (errors == 0 && rewritten_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
hdl/srs_pkg.sv
hdl/srs_emit.sv
hdl/substring_replace_stream.sv
dv/tb.sv
